/* sv/tocc_pkg.sv */
// Shared types, constants and codes for the topological order core.
package tocc_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int EdgeW = $clog2(MaxEdges);
    localparam int CountW = $clog2(MaxNodes + 1);
    localparam int TotalW = $clog2(MaxEdges + 1);

    localparam logic [1:0] StatusOrder = 2'd0;
    localparam logic [1:0] StatusCycle = 2'd1;
    localparam logic [1:0] StatusEmpty = 2'd2;
    localparam logic [1:0] StatusOverflow = 2'd3;

    localparam logic OpLoad = 1'b0;
    localparam logic OpRun = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROOT,
        ST_FETCH,
        ST_SCAN,
        ST_EXAMINE,
        ST_FINISH,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT,
        ST_SINGLE
    } state_t;

endpackage

/* sv/topological_order_with_cycle_check_core.sv */
// Depth-first topological sort core with cycle detection.
// Sequence: a load item is written straight into the edge store. A run takes each node index
// as a root and scans edges from each frame's resume point to the end of the scan. It then
// finishes a node and resumes its parent. Last it gives the order results, or a single
// status result.
// Throughput: loads one per cycle; a run blocks input until its last result is taken.
// Reset (aresetn, synchronous, active low) clears node count, edge count, overflow flag and the
// sequencer.
module topological_order_with_cycle_check_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // course_before[5:0], course_after[11:6], zero fill
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // course[5:0], status[7:6]
    output logic        m_tlast    // last
);
    import tocc_pkg::*;

    logic [6:0] node_count_reg;
    logic [TotalW-1:0] edge_total_reg;
    logic overflowed_reg;
    state_t state_reg, state_next;
    logic [MaxNodes-1:0] visited_reg, on_path_reg;
    logic [CountW-1:0] root_reg;
    logic [CountW-1:0] depth_reg, finish_count_reg, emit_reg;
    logic [NodeW-1:0] top_node_reg;
    logic [TotalW-1:0] k_reg;
    logic [1:0] single_status_reg;
    logic m_valid_reg, m_last_reg;
    logic [NodeW-1:0] m_course_reg;
    logic [1:0] m_status_reg;

    logic [CountW-1:0] nc;
    assign nc = (node_count_reg > 7'(MaxNodes)) ? CountW'(MaxNodes) : CountW'(node_count_reg);

    // Edge store: before and after packed in one word.
    logic edge_we;
    logic [EdgeW-1:0] edge_raddr;
    logic [2*NodeW-1:0] edge_rdata;
    logic [NodeW-1:0] in_before, in_after;
    assign in_before = s_tdata[NodeW-1:0];
    assign in_after = s_tdata[2*NodeW-1:NodeW];
    logic load_acc;
    assign load_acc = s_tvalid && s_tready && (s_tuser == OpLoad);
    logic load_ok;
    assign load_ok = ({1'b0, in_before} < nc) && ({1'b0, in_after} < nc)
                     && (edge_total_reg < TotalW'(MaxEdges));
    assign edge_we = load_acc && load_ok;

    tocc_ram #(.Width(2*NodeW), .Depth(MaxEdges)) u_edges (
        .aclk(aclk), .we(edge_we), .waddr(edge_total_reg[EdgeW-1:0]),
        .wdata({in_after, in_before}), .raddr(edge_raddr), .rdata(edge_rdata));

    // Walk stack: node and resume edge index per level.
    logic ws_we;
    logic [NodeW-1:0] ws_waddr, ws_raddr;
    logic [NodeW+TotalW-1:0] ws_wdata, ws_rdata;
    tocc_ram #(.Width(NodeW+TotalW), .Depth(MaxNodes)) u_walk (
        .aclk(aclk), .we(ws_we), .waddr(ws_waddr), .wdata(ws_wdata),
        .raddr(ws_raddr), .rdata(ws_rdata));

    // Finish stack.
    logic fs_we;
    logic [NodeW-1:0] fs_waddr, fs_raddr, fs_rdata;
    tocc_ram #(.Width(NodeW), .Depth(MaxNodes)) u_finish (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(top_node_reg),
        .raddr(fs_raddr), .rdata(fs_rdata));

    logic run_acc;
    assign run_acc = s_tvalid && s_tready && (s_tuser == OpRun);
    assign s_tready = (state_reg == ST_IDLE) && !m_valid_reg;

    logic [NodeW-1:0] v;
    assign v = edge_rdata[2*NodeW-1:NodeW];

    // Combinational sequencer.
    logic push, out_load, out_single;
    always_comb begin
        state_next = state_reg;
        edge_raddr = k_reg[EdgeW-1:0];
        ws_we = 1'b0;
        // A push saves the parent frame at depth-1 with its resume index.
        ws_waddr = NodeW'(depth_reg - CountW'(1));
        ws_wdata = {top_node_reg, k_reg};
        ws_raddr = NodeW'(depth_reg - CountW'(1));
        fs_we = 1'b0;
        fs_waddr = finish_count_reg[NodeW-1:0];
        fs_raddr = NodeW'(finish_count_reg - CountW'(1) - emit_reg);
        push = 1'b0;
        out_load = 1'b0;
        out_single = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (run_acc) begin
                    if (overflowed_reg || nc == '0) begin
                        state_next = ST_SINGLE;
                    end else begin
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (root_reg >= nc) begin
                    state_next = (finish_count_reg == '0) ? ST_IDLE : ST_EMIT_RD;
                end else if (visited_reg[root_reg[NodeW-1:0]]) begin
                    state_next = ST_ROOT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue read of edge k for the top node.
                if (k_reg >= edge_total_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_EXAMINE;
                end
            end
            ST_EXAMINE: begin
                if (edge_rdata[NodeW-1:0] != top_node_reg || {1'b0, v} >= nc) begin
                    state_next = ST_SCAN;
                end else if (!visited_reg[v]) begin
                    ws_we = 1'b1;
                    push = 1'b1;
                    state_next = ST_SCAN;
                end else if (on_path_reg[v]) begin
                    state_next = ST_SINGLE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH: begin
                fs_we = 1'b1;
                state_next = (depth_reg == CountW'(1)) ? ST_ROOT : ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_POP;
            end
            ST_POP: begin
                state_next = ST_SCAN;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load = 1'b1;
                    state_next = (emit_reg + CountW'(1) == finish_count_reg) ? ST_IDLE
                                                                            : ST_EMIT_RD;
                end
            end
            ST_SINGLE: begin
                if (!m_valid_reg || m_tready) begin
                    out_single = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            node_count_reg <= '0;
            edge_total_reg <= '0;
            overflowed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            finish_count_reg <= '0;
            depth_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
            if (load_acc) begin
                if (load_ok) begin
                    edge_total_reg <= edge_total_reg + TotalW'(1);
                end else begin
                    overflowed_reg <= 1'b1;
                end
            end
            if (out_load || out_single) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (run_acc) begin
                        single_status_reg <= overflowed_reg ? StatusOverflow : StatusEmpty;
                        edge_total_reg <= edge_total_reg;
                        visited_reg <= '0;
                        on_path_reg <= '0;
                        finish_count_reg <= '0;
                        root_reg <= '0;
                        emit_reg <= '0;
                        depth_reg <= '0;
                    end
                end
                ST_ROOT: begin
                    if (root_reg < nc) begin
                        if (!visited_reg[root_reg[NodeW-1:0]]) begin
                            visited_reg[root_reg[NodeW-1:0]] <= 1'b1;
                            on_path_reg[root_reg[NodeW-1:0]] <= 1'b1;
                            top_node_reg <= root_reg[NodeW-1:0];
                            k_reg <= '0;
                            depth_reg <= CountW'(1);
                        end
                        root_reg <= root_reg + CountW'(1);
                    end else begin
                        // Walk complete; the run empties the edge store.
                        edge_total_reg <= '0;
                        overflowed_reg <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (k_reg < edge_total_reg) begin
                        k_reg <= k_reg + TotalW'(1);
                    end
                end
                ST_EXAMINE: begin
                    if (push) begin
                        visited_reg[v] <= 1'b1;
                        on_path_reg[v] <= 1'b1;
                        top_node_reg <= v;
                        k_reg <= '0;
                        depth_reg <= depth_reg + CountW'(1);
                    end else if (state_next == ST_SCAN) begin
                        k_reg <= k_reg;
                    end else begin
                        single_status_reg <= StatusCycle;
                    end
                end
                ST_FINISH: begin
                    on_path_reg[top_node_reg] <= 1'b0;
                    finish_count_reg <= finish_count_reg + CountW'(1);
                    depth_reg <= depth_reg - CountW'(1);
                end
                ST_POP: begin
                    top_node_reg <= ws_rdata[NodeW+TotalW-1:TotalW];
                    k_reg <= ws_rdata[TotalW-1:0];
                end
                ST_EMIT: begin
                    if (out_load) begin
                        emit_reg <= emit_reg + CountW'(1);
                        m_course_reg <= fs_rdata;
                        m_status_reg <= StatusOrder;
                        m_last_reg <= (emit_reg + CountW'(1) == finish_count_reg);
                    end
                end
                ST_SINGLE: begin
                    if (out_single) begin
                        m_course_reg <= '0;
                        m_status_reg <= single_status_reg;
                        m_last_reg <= 1'b1;
                        edge_total_reg <= '0;
                        overflowed_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {m_status_reg, m_course_reg};
    assign m_tlast = m_last_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while a run is in progress");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_tdata)))
        else $error("pending result changed before it was taken");
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (depth_reg <= CountW'(MaxNodes)) && (finish_count_reg <= CountW'(MaxNodes)))
        else $error("walk or finish stack exceeded its depth");
`endif
endmodule

/* sv/tocc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module tocc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* bench/tb_topological_order_with_cycle_check_core.sv */
// Self-checking bench for the depth-first topological sort core with cycle detection.
`timescale 1ns / 100ps

module tb_topological_order_with_cycle_check_core;
    import tocc_pkg::*;

    typedef struct packed {
        logic       op;
        logic [5:0] before_node;
        logic [5:0] after_node;
    } edge_item_t;

    typedef struct packed {
        logic [5:0] course;
        logic [1:0] status;
        logic       last;
    } order_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    topological_order_with_cycle_check_core dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    // Predictor state.
    int unsigned nodes_reg;
    logic [5:0]  pred_before[MaxEdges];
    logic [5:0]  pred_after[MaxEdges];
    int unsigned pred_edges;
    bit          pred_overflow;

    edge_item_t  pending_items[$];
    order_item_t expected_order[$];
    int          failures = 0;
    longint      cycle_count = 0;
    bit          hold_off_req = 0;

    function automatic void predict_item(edge_item_t it);
        int unsigned nc;
        bit          seen[MaxNodes];
        bit          on_path[MaxNodes];
        int          stk_node[MaxNodes];
        int unsigned stk_edge[MaxNodes];
        int          finished[$];
        int          depth;
        bit          loop_found;
        bit          descended;
        int unsigned k;
        int          v;
        order_item_t r;
        nc = (nodes_reg > MaxNodes) ? MaxNodes : nodes_reg;
        if (it.op == OpLoad) begin
            if (it.before_node >= nc || it.after_node >= nc || pred_edges >= MaxEdges)
                pred_overflow = 1;
            else begin
                pred_before[pred_edges] = it.before_node;
                pred_after[pred_edges] = it.after_node;
                pred_edges++;
            end
            return;
        end
        loop_found = 0;
        foreach (seen[i]) begin
            seen[i] = 0;
            on_path[i] = 0;
        end
        if (pred_overflow) begin
            r = '{6'd0, StatusOverflow, 1'b1};
            expected_order.insert(expected_order.size(), r);
        end else if (nc == 0) begin
            r = '{6'd0, StatusEmpty, 1'b1};
            expected_order.insert(expected_order.size(), r);
        end else begin
            for (int root = 0; root < nc && !loop_found; root++) begin
                if (seen[root]) continue;
                seen[root] = 1;
                on_path[root] = 1;
                stk_node[0] = root;
                stk_edge[0] = 0;
                depth = 1;
                while (depth > 0 && !loop_found) begin
                    k = stk_edge[depth-1];
                    descended = 0;
                    while (k < pred_edges && !loop_found) begin
                        if (pred_before[k] != stk_node[depth-1]) begin
                            k++;
                            continue;
                        end
                        v = pred_after[k];
                        k++;
                        if (v >= nc) continue;
                        if (!seen[v]) begin
                            stk_edge[depth-1] = k;
                            seen[v] = 1;
                            on_path[v] = 1;
                            stk_node[depth] = v;
                            stk_edge[depth] = 0;
                            depth++;
                            descended = 1;
                            break;
                        end else if (on_path[v]) begin
                            loop_found = 1;
                        end
                    end
                    if (!descended && !loop_found) begin
                        on_path[stk_node[depth-1]] = 0;
                        finished.insert(finished.size(), stk_node[depth-1]);
                        depth--;
                    end
                end
            end
            if (loop_found) begin
                r = '{6'd0, StatusCycle, 1'b1};
                expected_order.insert(expected_order.size(), r);
            end else begin
                for (int i = finished.size() - 1; i >= 0; i--) begin
                    r = '{finished[i][5:0], StatusOrder, i == 0};
                    expected_order.insert(expected_order.size(), r);
                end
            end
        end
        pred_edges = 0;
        pred_overflow = 0;
    endfunction

    // Driver: each item waits a random gap; a predicted item is registered on acceptance.
    int drv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_item('{s_tuser, s_tdata[5:0], s_tdata[11:6]});
                void'(pending_items.pop_front());
                drv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (drv_gap > 0 || pending_items.size() == 0) begin
                if (drv_gap > 0) drv_gap--;
                s_tvalid <= 1'b0;
            end else if (!(s_tvalid && !s_tready) || s_tvalid) begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_items[0].op;
                s_tdata <= {4'd0, pending_items[0].after_node, pending_items[0].before_node};
            end
        end
    end

    // Monitor and receiver stall.
    int rcv_gap = 0;
    int hold_cnt = 0;
    order_item_t got, want;
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[5:0], m_tdata[7:6], m_tlast};
                if (expected_order.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %p", $time, got);
                    failures++;
                end else begin
                    want = expected_order.pop_front();
                    if (got.course !== want.course)
                        $display("%0t: course mismatch expected %0d actual %0d",
                                 $time, want.course, got.course);
                    if (got.status !== want.status)
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, got.status);
                    if (got.last !== want.last)
                        $display("%0t: last mismatch expected %0d actual %0d",
                                 $time, want.last, got.last);
                    if (got !== want) failures++;
                end
                rcv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            end
            if (hold_off_req && hold_cnt == 0) hold_cnt = 3000;
            if (hold_cnt > 0) begin
                hold_cnt--;
                if (hold_cnt == 0) hold_off_req = 0;
                m_tready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
        if (cycle_count > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(bit op, int b, int a);
        edge_item_t it;
        it = '{op, b[5:0], a[5:0]};
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_order.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_nodes(int n);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= n[6:0];
        nodes_reg = n;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random graph and a run: mostly forward edges (acyclic), sometimes a back edge or a far target.
    task automatic random_graph(int n, int edges);
        int b, a;
        for (int i = 0; i < edges; i++) begin
            b = $urandom_range(0, n - 1);
            a = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) != 0 && b > a) begin
                int t;
                t = a; a = b; b = t;
            end
            if ($urandom_range(0, 29) == 0) a = $urandom_range(0, 63);
            add_item(OpLoad, b, a);
        end
        add_item(OpRun, $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    initial begin
        int n;
        nodes_reg = 0;
        pred_edges = 0;
        pred_overflow = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Zero nodes with reset value, then an edge that overflows.
        add_item(OpRun, 63, 63);
        add_item(OpLoad, 0, 0);
        add_item(OpRun, 0, 0);
        drain();
        set_nodes(4);
        add_item(OpLoad, 0, 1);
        add_item(OpLoad, 1, 2);
        add_item(OpLoad, 0, 3);
        add_item(OpRun, 21, 42);
        add_item(OpLoad, 2, 2);
        add_item(OpRun, 0, 0);
        add_item(OpLoad, 0, 1);
        add_item(OpLoad, 1, 0);
        add_item(OpRun, 0, 0);
        drain();
        set_nodes(127);
        add_item(OpLoad, 63, 0);
        add_item(OpLoad, 0, 63);
        add_item(OpLoad, 42, 21);
        add_item(OpRun, 0, 0);
        drain();
        // Load wide, then shrink: out-of-range targets are skipped in the walk.
        add_item(OpLoad, 1, 50);
        add_item(OpLoad, 0, 1);
        drain();
        set_nodes(2);
        add_item(OpRun, 0, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        set_nodes(64);
        hold_off_req = 1;
        random_graph(64, 10);
        random_graph(64, 5);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            n = (phase == 4) ? 64 : $urandom_range(1, 12);
            set_nodes(n);
            for (int g = 0; g < 4; g++) random_graph(n, $urandom_range(0, 8));
            add_item($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63));
            add_item(OpRun, 0, 0);
            drain();
        end
        set_nodes(0);
        add_item(OpRun, 0, 0);
        drain();

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
